// ===== hdl/kbf_pkg.sv =====
// ----------------------------------------------------------------------------
// kbf_pkg
// Shared types and constants for the keyboard key FIFO register port.
// ----------------------------------------------------------------------------
package kbf_pkg;

    // default depth of the key FIFO
    localparam int DEFAULT_FIFO_DEPTH = 16;

    // operation codes
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_KEY   = 2'd2;

    // register addresses
    localparam logic [15:0] ADDR_DATA   = 16'd0;
    localparam logic [15:0] ADDR_STATUS = 16'd1;

    // status byte bits
    localparam logic [7:0] STAT_ENABLE   = 8'h01;
    localparam logic [7:0] STAT_PENDING  = 8'h02;
    localparam logic [7:0] STAT_NOTEMPTY = 8'h04;

    // one incoming transaction
    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [7:0]  key_code;
    } item_t;

    // one returned transaction
    typedef struct packed {
        logic [7:0] read_data;
        logic       interrupt_pending;
    } result_t;

    // controller commands to the datapath
    typedef struct packed {
        logic capture;
        logic execute;
    } ctrl_t;

endpackage

// ===== hdl/kbf_ctrl.sv =====
// ----------------------------------------------------------------------------
// kbf_ctrl
// Sequencer: takes a transaction, runs the execute state, then strobes the
// result. A new transaction may be taken while the result is shown.
// ----------------------------------------------------------------------------
module kbf_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    output logic           done,
    output kbf_pkg::ctrl_t ctrl
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_RESP = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    // handshake
    assign busy   = (state_reg == ST_EXEC);
    assign done   = (state_reg == ST_RESP);
    assign accept = start && !busy;

    // commands
    assign ctrl.capture = accept;
    assign ctrl.execute = (state_reg == ST_EXEC);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                state_next = accept ? ST_EXEC : ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/kbf_datapath.sv =====
// ----------------------------------------------------------------------------
// kbf_datapath
// Key FIFO memory, pointers, fill count, enable and pending flags, and the
// result registers.
// ----------------------------------------------------------------------------
module kbf_datapath
#(
    parameter int FIFO_DEPTH = kbf_pkg::DEFAULT_FIFO_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  kbf_pkg::ctrl_t   ctrl,
    input  kbf_pkg::item_t   item,
    output kbf_pkg::result_t result
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

    kbf_pkg::item_t   item_reg;
    logic [7:0]       mem [FIFO_DEPTH];
    logic [7:0]       mem_q_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             enable_reg;
    logic             enable_next;
    logic             pending_reg;
    logic             pending_next;
    logic [7:0]       rdata_reg;
    logic [7:0]       rdata_next;
    logic             pop_sel_reg;
    logic             do_pop;
    logic             do_push;
    logic             is_read;
    logic             is_write;
    logic             is_key;
    logic [7:0]       status;

    // capture the transaction
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            item_reg <= item;
        end
    end

    // decode
    assign is_read  = (item_reg.operation == kbf_pkg::OP_READ);
    assign is_write = (item_reg.operation == kbf_pkg::OP_WRITE);
    assign is_key   = (item_reg.operation == kbf_pkg::OP_KEY);
    assign do_pop   = is_read && (item_reg.address == kbf_pkg::ADDR_DATA)
                      && (count_reg != '0);
    assign do_push  = is_key && (count_reg != CNT_FULL);

    assign status = (enable_reg ? kbf_pkg::STAT_ENABLE : 8'h00)
                  | (pending_reg ? kbf_pkg::STAT_PENDING : 8'h00)
                  | ((count_reg != '0) ? kbf_pkg::STAT_NOTEMPTY : 8'h00);

    // pointer, count, flag and read data updates
    always_comb
    begin
        rd_ptr_next  = rd_ptr_reg;
        wr_ptr_next  = wr_ptr_reg;
        count_next   = count_reg;
        enable_next  = enable_reg;
        pending_next = pending_reg;
        rdata_next   = 8'h00;
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            count_next  = count_reg - CNT_W'(1);
        end
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            count_next  = count_reg + CNT_W'(1);
        end
        if (is_read && (item_reg.address == kbf_pkg::ADDR_STATUS))
        begin
            rdata_next = status;
        end
        if (is_write && (item_reg.address == kbf_pkg::ADDR_STATUS))
        begin
            enable_next  = item_reg.write_data[0];
            pending_next = 1'b0;
        end
        if (is_key && enable_reg)
        begin
            pending_next = 1'b1;
        end
    end

    // key memory, registered read at the read pointer
    always_ff @(posedge clk)
    begin
        if (ctrl.execute)
        begin
            if (do_push)
            begin
                mem[wr_ptr_reg] <= item_reg.key_code;
            end
            mem_q_reg <= mem[rd_ptr_reg];
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (ctrl.execute)
        begin
            rdata_reg <= rdata_next;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg  <= '0;
            wr_ptr_reg  <= '0;
            count_reg   <= '0;
            enable_reg  <= 1'b0;
            pending_reg <= 1'b0;
            pop_sel_reg <= 1'b0;
        end
        else if (ctrl.execute)
        begin
            rd_ptr_reg  <= rd_ptr_next;
            wr_ptr_reg  <= wr_ptr_next;
            count_reg   <= count_next;
            enable_reg  <= enable_next;
            pending_reg <= pending_next;
            pop_sel_reg <= do_pop;
        end
    end

    // result out
    assign result.read_data         = pop_sel_reg ? mem_q_reg : rdata_reg;
    assign result.interrupt_pending = pending_reg;

endmodule

// ===== hdl/keyboard_fifo_register_port.sv =====
// ----------------------------------------------------------------------------
// keyboard_fifo_register_port
// Keyboard peripheral: key FIFO behind a data and a status/control register.
// ----------------------------------------------------------------------------
// result: strobed on done in the state after the execute state
// a new transaction is held off by busy in the execute state that reads the key
//   memory into its registered output, and may be taken while the result is shown
// busy is high only in the execute state; the result must be taken when shown
// reset: FIFO empty, keyboard disabled, no interrupt pending; key memory
//   contents are not cleared
module keyboard_fifo_register_port
#(
    parameter int FIFO_DEPTH = kbf_pkg::DEFAULT_FIFO_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  kbf_pkg::item_t   item,
    output logic             done,
    output kbf_pkg::result_t result
);

    kbf_pkg::ctrl_t ctrl;

    // sequencer
    kbf_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .ctrl  (ctrl)
    );

    // datapath
    kbf_datapath
    #(
        .FIFO_DEPTH (FIFO_DEPTH)
    )
    u_datapath
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .item   (item),
        .result (result)
    );

    // accepted transaction goes to execute next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not execute");

    // every execute cycle is followed by exactly one result strobe
    assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (done && !busy))
        else $error("execute not followed by result");

    // no result without a preceding execute cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without execute");

endmodule

// ===== test/kbf_checker.sv =====
// ----------------------------------------------------------------------------
// kbf_checker
// Watches the command and result channels of the keyboard key FIFO port,
// keeps its own copy of the FIFO, enable and pending state, predicts each
// result and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module kbf_checker
#(
    parameter int DEPTH = kbf_pkg::DEFAULT_FIFO_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             busy,
    input  kbf_pkg::item_t   item,
    input  logic             done,
    input  kbf_pkg::result_t result,
    output int               outstanding,
    output int               fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PTR_W = $clog2(DEPTH);

    // shadow of the keyboard state
    logic [7:0]       key_mem [DEPTH];
    logic [PTR_W-1:0] rd_ptr;
    logic [PTR_W-1:0] wr_ptr;
    logic [PTR_W:0]   key_count;
    logic             kbd_enable;
    logic             irq_pending;

    // predicted results, oldest first
    kbf_pkg::result_t expected_results [$];
    kbf_pkg::result_t oldest;

    initial fail_count = 0;

    // advance a FIFO pointer with wrap at the configured depth
    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // apply one transaction to the shadow state and return its result
    function automatic kbf_pkg::result_t keyboard_step(input kbf_pkg::item_t it);
        kbf_pkg::result_t r;
        r.read_data = 8'h00;
        case (it.operation)
            kbf_pkg::OP_READ:
            begin
                if (it.address == kbf_pkg::ADDR_DATA)
                begin
                    // pop a key, or read zero when empty
                    if (key_count != 0)
                    begin
                        r.read_data = key_mem[rd_ptr];
                        rd_ptr      = next_slot(rd_ptr);
                        key_count   = key_count - 1'b1;
                    end
                end
                else if (it.address == kbf_pkg::ADDR_STATUS)
                begin
                    r.read_data = (kbd_enable  ? kbf_pkg::STAT_ENABLE  : 8'h00) |
                                  (irq_pending ? kbf_pkg::STAT_PENDING : 8'h00) |
                                  ((key_count != 0) ? kbf_pkg::STAT_NOTEMPTY : 8'h00);
                end
            end
            kbf_pkg::OP_WRITE:
            begin
                // only the control register responds, bit0 is enable
                if (it.address == kbf_pkg::ADDR_STATUS)
                begin
                    kbd_enable  = it.write_data[0];
                    irq_pending = 1'b0;
                end
            end
            kbf_pkg::OP_KEY:
            begin
                // key is dropped when full, pending is still raised if enabled
                if (key_count < (PTR_W + 1)'(DEPTH))
                begin
                    key_mem[wr_ptr] = it.key_code;
                    wr_ptr          = next_slot(wr_ptr);
                    key_count       = key_count + 1'b1;
                end
                if (kbd_enable)
                    irq_pending = 1'b1;
            end
            default:
            begin
            end
        endcase
        r.interrupt_pending = irq_pending;
        return r;
    endfunction

    // compare strobed results and predict each accepted transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr      = '0;
            wr_ptr      = '0;
            key_count   = '0;
            kbd_enable  = 1'b0;
            irq_pending = 1'b0;
            expected_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: read_data %0h interrupt_pending %0b",
                           result.read_data, result.interrupt_pending);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    if (result.read_data !== oldest.read_data)
                    begin
                        $error("read_data mismatch: expected %0h actual %0h",
                               oldest.read_data, result.read_data);
                        fail_count = fail_count + 1;
                    end
                    if (result.interrupt_pending !== oldest.interrupt_pending)
                    begin
                        $error("interrupt_pending mismatch: expected %0b actual %0b",
                               oldest.interrupt_pending, result.interrupt_pending);
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (start && !busy)
                expected_results.push_back(keyboard_step(item));
            outstanding <= expected_results.size();
        end
    end

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives bus reads, bus writes and key arrivals into the keyboard key FIFO
// port: a directed pass over the registers and the empty and full cases,
// then bursts of random transactions under several idle patterns. The
// checker beside the block reports failures for the final verdict.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // operation code with no effect
    localparam logic [1:0] OP_NOP = 2'd3;

    localparam int PHASE_COUNT     = 6;
    localparam int ITEMS_PER_PHASE = 242;

    typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} burst_mode_t;

    logic             clk;
    logic             rst_n;
    logic             start;
    logic             busy;
    kbf_pkg::item_t   item;
    logic             done;
    kbf_pkg::result_t result;
    int               outstanding;
    int               fail_count;
    int               idle_pct;
    int               phase_idle [3] = '{0, 46, 26};

    keyboard_fifo_register_port dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    kbf_checker u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .item        (item),
        .done        (done),
        .result      (result),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run time limit
    initial
    begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic kbf_pkg::item_t make_item(input logic [1:0] op,
                                                 input logic [15:0] addr,
                                                 input logic [7:0] wd,
                                                 input logic [7:0] kc);
        kbf_pkg::item_t it;
        it.operation  = op;
        it.address    = addr;
        it.write_data = wd;
        it.key_code   = kc;
        return it;
    endfunction

    // random transaction, weighted by the current burst mode
    function automatic kbf_pkg::item_t pick_transaction(input burst_mode_t mode);
        kbf_pkg::item_t it;
        int             roll;
        it.write_data = 8'($urandom_range(255));
        it.key_code   = 8'($urandom_range(255));
        it.address    = 16'($urandom_range(65535));
        roll = $urandom_range(99);
        if (roll < 3)
            it.operation = OP_NOP;
        else if (mode == MODE_FILL)
            it.operation = (roll < 70) ? kbf_pkg::OP_KEY :
                           ((roll < 88) ? kbf_pkg::OP_READ : kbf_pkg::OP_WRITE);
        else if (mode == MODE_DRAIN)
            it.operation = (roll < 75) ? kbf_pkg::OP_READ :
                           ((roll < 88) ? kbf_pkg::OP_KEY : kbf_pkg::OP_WRITE);
        else
            it.operation = (roll < 36) ? kbf_pkg::OP_READ :
                           ((roll < 68) ? kbf_pkg::OP_WRITE : kbf_pkg::OP_KEY);
        // most register accesses go to the two mapped addresses
        roll = $urandom_range(99);
        if (roll < 90)
        begin
            if (it.operation == kbf_pkg::OP_WRITE)
                it.address = (roll < 10) ? kbf_pkg::ADDR_DATA : kbf_pkg::ADDR_STATUS;
            else if (mode == MODE_DRAIN)
                it.address = (roll < 75) ? kbf_pkg::ADDR_DATA : kbf_pkg::ADDR_STATUS;
            else
                it.address = (roll < 50) ? kbf_pkg::ADDR_DATA : kbf_pkg::ADDR_STATUS;
        end
        return it;
    endfunction

    // present one transaction after a random idle gap, return once accepted
    task automatic issue_transaction(input kbf_pkg::item_t it);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // hold off until every predicted result has arrived
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // stimulus
    initial
    begin : stimulus
        burst_mode_t mode;
        int          burst_left;

        start    = 1'b0;
        item     = '0;
        rst_n    = 1'b0;
        idle_pct = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: status after reset, pop when empty, disabled key
        issue_transaction(make_item(kbf_pkg::OP_READ,  kbf_pkg::ADDR_STATUS, 8'h00, 8'h00));
        issue_transaction(make_item(kbf_pkg::OP_READ,  kbf_pkg::ADDR_DATA,   8'h00, 8'h00));
        issue_transaction(make_item(kbf_pkg::OP_KEY,   16'hFFFF,             8'hFF, 8'h00));
        issue_transaction(make_item(kbf_pkg::OP_READ,  kbf_pkg::ADDR_STATUS, 8'h00, 8'h00));
        // enable with all bits set, key raises pending
        issue_transaction(make_item(kbf_pkg::OP_WRITE, kbf_pkg::ADDR_STATUS, 8'hFF, 8'h00));
        issue_transaction(make_item(kbf_pkg::OP_KEY,   16'h0000,             8'h00, 8'hFF));
        issue_transaction(make_item(kbf_pkg::OP_READ,  kbf_pkg::ADDR_STATUS, 8'h00, 8'h00));
        // unmapped writes and reads, no-op code
        issue_transaction(make_item(kbf_pkg::OP_WRITE, kbf_pkg::ADDR_DATA,   8'hAA, 8'h55));
        issue_transaction(make_item(kbf_pkg::OP_WRITE, 16'hFFFF,             8'h00, 8'hFF));
        issue_transaction(make_item(kbf_pkg::OP_READ,  16'hFFFF,             8'hFF, 8'hFF));
        issue_transaction(make_item(kbf_pkg::OP_READ,  16'h0002,             8'h00, 8'h00));
        issue_transaction(make_item(OP_NOP,            kbf_pkg::ADDR_DATA,   8'hFF, 8'hFF));
        // disable with bit0 clear, pending acknowledged
        issue_transaction(make_item(kbf_pkg::OP_WRITE, kbf_pkg::ADDR_STATUS, 8'hFE, 8'h00));
        issue_transaction(make_item(kbf_pkg::OP_WRITE, kbf_pkg::ADDR_STATUS, 8'h01, 8'h00));
        // fill to full, the last key is dropped but still raises pending
        for (int i = 0; i < 15; i++)
            issue_transaction(make_item(kbf_pkg::OP_KEY, kbf_pkg::ADDR_DATA, 8'h00,
                                        8'($urandom_range(255))));
        wait_drained();

        // random bursts under each idle pattern
        burst_left = 0;
        mode       = MODE_MIX;
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            idle_pct = phase_idle[p % 3];
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (burst_left == 0)
                begin
                    mode       = burst_mode_t'($urandom_range(2));
                    burst_left = $urandom_range(40, 1);
                end
                burst_left--;
                issue_transaction(pick_transaction(mode));
                if (n == ITEMS_PER_PHASE / 2)
                    wait_drained();
            end
        end

        // drain and let the pipeline settle
        wait_drained();
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
